>>> src/nltp_pkg.sv
package nltp_pkg;

  localparam int SEGMENTS = 64;
  localparam int TERMS = 8;
  localparam int ROW_W = $clog2(SEGMENTS);
  localparam int TERM_W = $clog2(TERMS);
  localparam int D_W = 52 - ROW_W;
  localparam int DH = (D_W + 1) / 2;
  localparam int D_SHIFT = 9;
  localparam int PROD_SHIFT = 60 - D_SHIFT;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  typedef logic [SEGMENTS-1:0][TERMS-1:0][63:0] coef_rom_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic signed [D_W-1:0] dd;
    logic signed [10:0] n;
    logic special;
  } qctx_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic signed [D_W-1:0] dd;
    logic signed [63:0] lnn;
    logic special;
  } bctx_t;

  function automatic logic [63:0] umul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    logic [127:0] t;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
    t = p >> s;
    return t[63:0];
  endfunction

  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    int i;
    rem = '0;
    q = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] divq(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    int i;
    q = '0;
    rem = num;
    for (i = 0; i < 60; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] two_atanh(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] pw;
    logic [63:0] sum;
    int j;
    t2 = umul_shr(t, t, 60);
    pw = t;
    sum = '0;
    for (j = 0; j < 40; j++) begin
      sum = sum + udiv(pw, 64'(2 * j + 1));
      pw = umul_shr(pw, t2, 60);
    end
    return sum << 1;
  endfunction

  localparam logic [63:0] LN2_Q60 = two_atanh(divq(64'd1, 64'd3));

  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    logic [63:0] inv;
    logic [63:0] p;
    logic [63:0] q;
    int r;
    int k;
    for (r = 0; r < SEGMENTS; r++) begin
      inv = divq(64'(SEGMENTS), 64'(2 * SEGMENTS + 2 * r + 1));
      p = 64'd1 << 60;
      rom[r][0] = LN2_Q60 + two_atanh(divq(64'(2 * r + 1), 64'(4 * SEGMENTS + 2 * r + 1)));
      for (k = 1; k < TERMS; k++) begin
        p = umul_shr(p, inv, 60);
        q = udiv(p + 64'(k >> 1), 64'(k));
        rom[r][k] = k[0] ? q : (64'd0 - q);
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

>>> src/nltp_in_if.sv
interface nltp_in_if;
  logic valid;
  logic ready;
  logic [63:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink (input valid, input x_bits, output ready);
endinterface

>>> src/nltp_out_if.sv
interface nltp_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] log_value;
  logic special_input;

  modport source (output valid, output log_value, output special_input, input ready);
  modport sink (input valid, input log_value, input special_input, output ready);
endinterface

>>> src/nltp_front.sv
module nltp_front (
  input  logic clk,
  input  logic rst,
  nltp_in_if.sink operand,
  output logic q_valid,
  output nltp_pkg::qctx_t q_ctx,
  input  logic q_pop
);
  import nltp_pkg::*;

  qctx_t slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0] count;
  logic push;
  logic pop;
  logic [10:0] ef;
  qctx_t cls;

  assign operand.ready = (count < (Q_AW + 1)'(Q_DEPTH));
  assign push = operand.valid && operand.ready;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != '0);
  assign q_ctx = slots[rd_ptr];

  always_comb begin
    ef = operand.x_bits[62:52];
    cls.row = operand.x_bits[51 -: ROW_W];
    cls.dd = {~operand.x_bits[D_W-1], operand.x_bits[D_W-2:0]};
    cls.n = {~ef[10], ef[9:0]};
    cls.special = operand.x_bits[63] || (ef == 11'd0) || (ef == 11'h7ff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW + 1)'(Q_DEPTH)) else $error("queue count overflow");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue push lost");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("queue pop lost");
endmodule

>>> src/nltp_horner_step.sv
module nltp_horner_step (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [nltp_pkg::TERM_W-1:0] term,
  input  logic in_valid,
  input  nltp_pkg::bctx_t in_ctx,
  input  logic signed [63:0] in_acc,
  output logic out_valid,
  output nltp_pkg::bctx_t out_ctx,
  output logic signed [63:0] out_acc
);
  import nltp_pkg::*;

  logic v1;
  logic v2;
  bctx_t c1;
  bctx_t c2;
  logic [63:0] amag;
  logic [2*DH-1:0] dmag;
  logic neg1;
  logic neg2;
  logic [32+DH-1:0] pp00;
  logic [32+DH-1:0] pp01;
  logic [32+DH-1:0] pp10;
  logic [32+DH-1:0] pp11;
  logic [127:0] full;
  logic [127:0] rnd;
  logic [63:0] m;
  logic signed [63:0] acc_next;

  always_comb begin
    full = 128'(pp00) + (128'(pp01) << DH) + (128'(pp10) << 32) + (128'(pp11) << (32 + DH));
    rnd = (full + (128'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
    m = rnd[63:0];
    acc_next = (neg2 ? (64'd0 - m) : m) + COEF_ROM[c2.row][term];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= in_ctx;
      amag <= in_acc[63] ? (64'd0 - in_acc) : in_acc;
      dmag <= (2*DH)'(in_ctx.dd[D_W-1] ? (D_W'(0) - in_ctx.dd) : in_ctx.dd);
      neg1 <= in_acc[63] ^ in_ctx.dd[D_W-1];
      c2 <= c1;
      neg2 <= neg1;
      pp00 <= amag[31:0] * dmag[DH-1:0];
      pp01 <= amag[31:0] * dmag[2*DH-1:DH];
      pp10 <= amag[63:32] * dmag[DH-1:0];
      pp11 <= amag[63:32] * dmag[2*DH-1:DH];
      out_ctx <= c2;
      out_acc <= acc_next;
    end
  end
endmodule

>>> src/nltp_back.sv
module nltp_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  nltp_pkg::qctx_t q_ctx,
  output logic q_pop,
  nltp_out_if.source result
);
  import nltp_pkg::*;

  logic en;
  logic sv [TERMS];
  bctx_t sc [TERMS];
  logic signed [63:0] sa [TERMS];
  logic s0_valid;
  bctx_t s0_ctx;
  logic signed [63:0] s0_acc;
  logic [10:0] nabs;
  logic [74:0] nprod;
  logic [63:0] nm;
  logic signed [63:0] acc_r;
  logic ov;

  assign en = !ov || result.ready;
  assign q_pop = en;
  assign result.valid = ov;

  assign sv[0] = s0_valid;
  assign sc[0] = s0_ctx;
  assign sa[0] = s0_acc;

  always_comb begin
    nabs = q_ctx.n[10] ? (11'd0 - q_ctx.n) : q_ctx.n;
    nprod = (75'(nabs) * 75'(LN2_Q60) + 75'd128) >> 8;
    nm = nprod[63:0];
    acc_r = (sa[TERMS-1] + 64'sd128) >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      s0_valid <= q_valid;
      ov <= sv[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctx.row <= q_ctx.row;
      s0_ctx.dd <= q_ctx.dd;
      s0_ctx.special <= q_ctx.special;
      s0_ctx.lnn <= q_ctx.n[10] ? (64'd0 - nm) : nm;
      s0_acc <= COEF_ROM[q_ctx.row][TERMS-1];
      result.log_value <= acc_r + sc[TERMS-1].lnn;
      result.special_input <= sc[TERMS-1].special;
    end
  end

  for (genvar i = 1; i < TERMS; i++) begin : g_step
    nltp_horner_step u_step (
      .clk(clk),
      .rst(rst),
      .en(en),
      .term(TERM_W'(TERMS - 1 - i)),
      .in_valid(sv[i-1]),
      .in_ctx(sc[i-1]),
      .in_acc(sa[i-1]),
      .out_valid(sv[i]),
      .out_ctx(sc[i]),
      .out_acc(sa[i])
    );
  end
endmodule

>>> src/natural_log_table_poly_unit.sv
// Natural logarithm of raw IEEE double bits, returned as signed Q11.52 with a flag for
// negative, zero, subnormal, infinite and NaN arguments (these are not handled specially).
// It accepts one item per clock unless a stalled result port has filled the input queue.
// An item passes the four-entry input queue, the table lookup and exponent term register,
// seven Horner steps (operands, partial products, sum registers) and the output register.
module natural_log_table_poly_unit (
  input logic clk,
  input logic rst,
  nltp_in_if.sink operand,
  nltp_out_if.source result
);
  import nltp_pkg::*;

  logic q_valid;
  qctx_t q_ctx;
  logic q_pop;

  nltp_front u_front (
    .clk(clk),
    .rst(rst),
    .operand(operand),
    .q_valid(q_valid),
    .q_ctx(q_ctx),
    .q_pop(q_pop)
  );

  nltp_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_ctx(q_ctx),
    .q_pop(q_pop),
    .result(result)
  );
endmodule

>>> dv/tb_natural_log_table_poly_unit.sv
`timescale 1ns / 100ps

module tb_natural_log_table_poly_unit;

  localparam int NSEG = nltp_pkg::SEGMENTS;
  localparam int NTERM = nltp_pkg::TERMS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [63:0] log_value;
    logic special_input;
  } log_result_t;

  class log_scoreboard;
    logic signed [63:0] coef [NSEG][NTERM];
    logic [63:0] ln2_fix;
    log_result_t pending_logs [$];
    int mismatches;

    static function logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
      p = p >> s;
      return p[63:0];
    endfunction

    static function logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q = '0;
      rem = num;
      for (int i = 0; i < 60; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    static function logic [63:0] atanh_twice(logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] pw;
      logic [63:0] sum;
      t2 = mul_round(t, t, 60);
      pw = t;
      sum = '0;
      for (int j = 0; j < 40; j++) begin
        sum = sum + pw / 64'(2 * j + 1);
        pw = mul_round(pw, t2, 60);
      end
      return sum << 1;
    endfunction

    static function logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    static function logic signed [63:0] signed_mul60(logic signed [63:0] a,
                                                     logic signed [63:0] b);
      logic [63:0] m;
      m = mul_round(magnitude(a), magnitude(b), 60);
      return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    function new();
      logic [63:0] inv;
      logic [63:0] p;
      logic [63:0] q;
      mismatches = 0;
      ln2_fix = atanh_twice(frac_div(64'd1, 64'd3));
      for (int r = 0; r < NSEG; r++) begin
        inv = frac_div(64'(NSEG), 64'(2 * NSEG + 2 * r + 1));
        p = 64'd1 << 60;
        coef[r][0] = ln2_fix + atanh_twice(frac_div(64'(2 * r + 1),
                                                    64'(4 * NSEG + 2 * r + 1)));
        for (int k = 1; k < NTERM; k++) begin
          p = mul_round(p, inv, 60);
          q = (p + 64'(k / 2)) / 64'(k);
          coef[r][k] = (k % 2 == 1) ? $signed(q) : -$signed(q);
        end
      end
    endfunction

    function log_result_t predict_log(logic [63:0] x);
      log_result_t res;
      logic [10:0] ef;
      logic [51:0] frac;
      int row;
      int odd;
      logic [63:0] centre;
      logic signed [63:0] n;
      logic signed [63:0] d;
      logic signed [63:0] acc;
      logic signed [63:0] w;
      logic signed [63:0] rounded;
      logic [63:0] nm;
      logic signed [63:0] lnn;
      ef = x[62:52];
      frac = x[51:0];
      n = $signed(64'(ef)) - 64'sd1024;
      row = int'((64'(frac) * NSEG) >> 52);
      if (row >= NSEG) row = NSEG - 1;
      odd = 2 * row + 1;
      centre = (64'(odd / NSEG) << 60) + frac_div(64'(odd % NSEG), 64'(NSEG));
      d = $signed(64'(frac) << 9) - $signed(centre);
      acc = coef[row][NTERM-1];
      for (int k = NTERM - 2; k >= 0; k--) begin
        acc = signed_mul60(acc, d) + coef[row][k];
      end
      nm = mul_round(magnitude(n), ln2_fix, 8);
      lnn = n < 0 ? -$signed(nm) : $signed(nm);
      w = acc + 64'sd128;
      if (w >= 0) rounded = w >>> 8;
      else rounded = -$signed((magnitude(w) + 64'd255) >> 8);
      res.log_value = rounded + lnn;
      res.special_input = x[63] | (ef == 11'd0) | (ef == 11'h7ff);
      return res;
    endfunction

    function void note_operand(logic [63:0] x);
      pending_logs.push_back(predict_log(x));
    endfunction

    function void check_result(logic signed [63:0] lv, logic sp);
      log_result_t exp_r;
      if (pending_logs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h flag %b", lv, sp);
        return;
      end
      exp_r = pending_logs.pop_front();
      if (exp_r.log_value !== lv || exp_r.special_input !== sp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h flag %b, got %h flag %b",
                   exp_r.log_value, exp_r.special_input, lv, sp);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  nltp_in_if operand_if();
  nltp_out_if result_if();

  natural_log_table_poly_unit i_dut (
    .clk(clk),
    .rst(rst),
    .operand(operand_if),
    .result(result_if)
  );

  log_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    sb = new();
    rst = 1'b1;
    operand_if.valid = 1'b0;
    operand_if.x_bits = '0;
    result_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("natural_log_table_poly_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (operand_if.valid && operand_if.ready) sb.note_operand(operand_if.x_bits);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.log_value, result_if.special_input);
    end
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_operand(logic [63:0] x);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) operand_if.valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    operand_if.valid <= 1'b1;
    operand_if.x_bits <= x;
    do @(posedge clk); while (!operand_if.ready);
  endtask

  task automatic drain_results();
    operand_if.valid <= 1'b0;
    while (sb.pending_logs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    int pick;
    x = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 55) x[62:52] = 11'(1023 + $urandom_range(60) - 30);
    else if (pick < 65) x[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
    else if (pick < 75) x[51:46] = 6'($urandom_range(1) ? 63 : 0);
    return x;
  endfunction

  initial begin
    logic [63:0] directed [$];
    directed = '{64'h0, 64'h8000000000000000, 64'h7ff0000000000000,
                 64'hfff0000000000000, 64'h7ff8000000000001, 64'h0000000000000001,
                 64'h000fffffffffffff, 64'h0010000000000000, 64'h3ff0000000000000,
                 64'h4000000000000000, 64'h400fffffffffffff, 64'h3fefffffffffffff,
                 64'h7fefffffffffffff, 64'hffffffffffffffff, 64'h4004000000000000,
                 64'h4003ffffffffffff, 64'h3ff0400000000000, 64'h3ff03fffffffffff,
                 64'h3ff0200000000000, 64'hbff8000000000000, 64'h5555555555555555,
                 64'haaaaaaaaaaaaaaaa};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_operand(directed[i]);
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < 330; i++) begin
        if (phase == 0 && i == 100) hold_left = 300;
        if (phase == 3 && i == 150) drain_results();
        send_operand(random_operand());
      end
    end
    operand_if.valid <= 1'b0;
    while (sb.pending_logs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_logs.size() == 0) begin
      $display("natural_log_table_poly_unit test passed");
    end else begin
      $display("natural_log_table_poly_unit test failed");
    end
    $finish;
  end

endmodule
